### rtl/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Shared types and constants of the text width measurement block.
// ----------------------------------------------------------------------------
package twm_pkg;

    localparam int GLYPH_SLOTS = 128;
    localparam int WIDTH_BITS  = 16;
    localparam int SLOT_BITS   = $clog2(GLYPH_SLOTS);

    localparam int TOTAL_BITS  = 31;
    localparam int HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    // Request types.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPACE_GAP    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GLYPH_HEIGHT = 1'd1;

    // Decoder modes.
    localparam logic [1:0] MODE_LEAD   = 2'd0;
    localparam logic [1:0] MODE_ACCENT = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    // Glyph index used for the width of a space.
    localparam logic [6:0] SPACE_GLYPH = 7'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  glyph_slot;
        logic [15:0] width_value;
        logic [7:0]  text_byte;
    } req_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0]  text_width;
        logic [HEIGHT_BITS-1:0] text_height;
        logic                   width_saturated;
    } res_t;

    // Outcome of decoding one text byte.
    typedef struct packed {
        logic       hit;
        logic       space;
        logic [6:0] idx;
    } glyph_t;

endpackage

### rtl/twm_req_if.sv
// ----------------------------------------------------------------------------
// twm_req_if
// Valid/ready channel that carries request items into the block.
// ----------------------------------------------------------------------------
interface twm_req_if
    import twm_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/twm_res_if.sv
// ----------------------------------------------------------------------------
// twm_res_if
// Valid/ready channel that carries measurement result items out of the block.
// ----------------------------------------------------------------------------
interface twm_res_if
    import twm_pkg::*;
();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/text_width_measure.sv
// ----------------------------------------------------------------------------
// text_width_measure
// Measures the pixel width of a byte string in a proportional font.
// ----------------------------------------------------------------------------
// Unless stalled, the block takes one item per clock cycle, whatever mix of
// table loads, text bytes and end-of-text items arrives. Load items write the
// glyph width table, a single-port synchronous RAM, and every entry that text
// will use must be loaded before it is measured. Text bytes are decoded as
// they are accepted: ASCII ranges, a 0xC3 prefix followed by an accented
// letter, a skipped 0xC2 pair, skipped three- and four-byte UTF-8 sequences,
// and a few Latin-1 capitals; unknown bytes are dropped. The decoded glyph
// index addresses the RAM in the accept cycle and, in the next cycle, the
// read width plus one pixel (or plus the space gap for a space) is added
// to a saturating 31-bit total. An end-of-text item, or a text byte of
// zero, passes the accumulate stage into the output register as one result
// holding the total less one (when positive), the configured font height
// and the saturation flag; the decoder clears on accept, the total when the
// result is loaded. The block keeps taking items while a result waits;
// input is held off only when a second end-of-text item reaches the
// accumulate stage before the previous result has been taken. The table
// needs no clearing after reset, so the block is ready at once.
// ----------------------------------------------------------------------------
module text_width_measure
    import twm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    twm_req_if.sink                   req,
    twm_res_if.source                 res
);

    // ------------------------------------------------------------------
    // Byte decoding tables.
    // ------------------------------------------------------------------
    function automatic glyph_t decode_lead(input logic [7:0] b);
        glyph_t g;
        g.hit   = 1'b1;
        g.space = 1'b0;
        g.idx   = 7'd0;
        if (b == 8'd32) begin
            g.space = 1'b1;
            g.idx   = SPACE_GLYPH;
        end else if (b >= 8'd33 && b <= 8'd47) begin
            g.idx = 7'(b - 8'd33 + 8'd64);
        end else if (b >= 8'd48 && b <= 8'd57) begin
            g.idx = 7'(b - 8'd48 + 8'd27);
        end else if (b >= 8'd58 && b <= 8'd64) begin
            g.idx = 7'(b - 8'd58 + 8'd79);
        end else if (b >= 8'd65 && b <= 8'd78) begin
            g.idx = 7'(b - 8'd65);
        end else if (b >= 8'd79 && b <= 8'd90) begin
            g.idx = 7'(b - 8'd79 + 8'd15);
        end else if (b >= 8'd91 && b <= 8'd93) begin
            g.idx = 7'(b - 8'd91 + 8'd86);
        end else if (b >= 8'd97 && b <= 8'd110) begin
            g.idx = 7'(b - 8'd97 + 8'd37);
        end else if (b >= 8'd111 && b <= 8'd122) begin
            g.idx = 7'(b - 8'd111 + 8'd52);
        end else if (b >= 8'd123 && b <= 8'd125) begin
            g.idx = 7'(b - 8'd123 + 8'd89);
        end else begin
            case (b)
                8'hD1:   g.idx = 7'd14;
                8'hC1:   g.idx = 7'd0;
                8'hC9:   g.idx = 7'd4;
                8'hCD:   g.idx = 7'd8;
                8'hD3:   g.idx = 7'd15;
                8'hDA:   g.idx = 7'd20;
                8'hDC:   g.idx = 7'd20;
                default: g.hit = 1'b0;
            endcase
        end
        return g;
    endfunction

    function automatic glyph_t decode_accent(input logic [7:0] b);
        glyph_t g;
        g.hit   = 1'b1;
        g.space = 1'b0;
        g.idx   = 7'd0;
        case (b)
            8'hA1:   g.idx = 7'd92;
            8'hA9:   g.idx = 7'd93;
            8'hAD:   g.idx = 7'd94;
            8'hB3:   g.idx = 7'd95;
            8'hBA:   g.idx = 7'd96;
            8'hB1:   g.idx = 7'd51;
            8'h91:   g.idx = 7'd14;
            8'h81:   g.idx = 7'd0;
            8'h89:   g.idx = 7'd4;
            8'h8D:   g.idx = 7'd8;
            8'h93:   g.idx = 7'd15;
            8'h9A:   g.idx = 7'd20;
            8'h9C:   g.idx = 7'd20;
            8'hBC:   g.idx = 7'd58;
            default: g.hit = 1'b0;
        endcase
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                   space_gap_reg;
    logic [HEIGHT_BITS-1:0] glyph_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_gap_reg    <= 1'b1;
            glyph_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPACE_GAP:    space_gap_reg    <= cfg_data[0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: request classification and byte decoding.
    // ------------------------------------------------------------------
    logic       accept;
    logic       s1_go;
    logic       is_load;
    logic       is_byte;
    logic       is_end;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] skip_reg, skip_next;
    glyph_t     glyph;

    assign accept  = req.valid && req.ready;
    assign is_load = (req.data.req_type == REQ_LOAD);
    assign is_byte = (req.data.req_type == REQ_BYTE) && (req.data.text_byte != 8'd0);
    assign is_end  = (req.data.req_type == REQ_END) ||
                     ((req.data.req_type == REQ_BYTE) && (req.data.text_byte == 8'd0));

    always_comb
    begin
        mode_next = mode_reg;
        skip_next = skip_reg;
        glyph     = '0;
        if (accept && is_end)
        begin
            mode_next = MODE_LEAD;
            skip_next = 2'd0;
        end
        else if (accept && is_byte)
        begin
            case (mode_reg)
                MODE_ACCENT:
                begin
                    mode_next = MODE_LEAD;
                    glyph     = decode_accent(req.data.text_byte);
                end
                MODE_SKIP:
                begin
                    skip_next = skip_reg - 2'd1;
                    if (skip_next == 2'd0)
                    begin
                        mode_next = MODE_LEAD;
                    end
                end
                default:
                begin
                    if (req.data.text_byte == 8'hC3)
                    begin
                        mode_next = MODE_ACCENT;
                    end
                    else if (req.data.text_byte == 8'hC2)
                    begin
                        mode_next = MODE_SKIP;
                        skip_next = 2'd1;
                    end
                    else if (req.data.text_byte[7:5] == 3'b111)
                    begin
                        // Three- and four-byte sequences skip their tail.
                        mode_next = MODE_SKIP;
                        skip_next = req.data.text_byte[4] ? 2'd3 : 2'd2;
                    end
                    else
                    begin
                        glyph = decode_lead(req.data.text_byte);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LEAD;
            skip_reg <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
        end
    end

    // ------------------------------------------------------------------
    // Glyph width memory: one write or one read per cycle.
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0] width_mem [GLYPH_SLOTS];
    logic [WIDTH_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;

    assign mem_we = accept && is_load && (32'(req.data.glyph_slot) < GLYPH_SLOTS);
    assign mem_re = accept && glyph.hit;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            width_mem[SLOT_BITS'(req.data.glyph_slot)] <=
                req.data.width_value[WIDTH_BITS-1:0];
        end
        if (mem_re)
        begin
            rd_data_reg <= width_mem[SLOT_BITS'(glyph.idx)];
        end
    end

    // ------------------------------------------------------------------
    // Accumulate stage.
    // ------------------------------------------------------------------
    logic                  s1_add_reg, s1_add_next;
    logic                  s1_space_reg, s1_space_next;
    logic                  s1_end_reg, s1_end_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_data_reg, out_data_next;
    logic [TOTAL_BITS:0]   sum;

    // The stage stalls only when it holds an end item and the previous
    // result has not been taken.
    assign s1_go     = !(s1_end_reg && out_valid_reg && !res.ready);
    assign req.ready = s1_go;

    assign sum = {1'b0, total_reg} + (TOTAL_BITS + 1)'(rd_data_reg)
               + (TOTAL_BITS + 1)'(s1_space_reg ? space_gap_reg : 1'b1);

    always_comb
    begin
        s1_add_next    = s1_add_reg;
        s1_space_next  = s1_space_reg;
        s1_end_next    = s1_end_reg;
        total_next     = total_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_data_next  = out_data_reg;
        if (s1_go)
        begin
            s1_add_next   = mem_re;
            s1_space_next = glyph.space;
            s1_end_next   = accept && is_end;
            if (s1_end_reg)
            begin
                out_valid_next                = 1'b1;
                out_data_next.text_width      = (total_reg != '0) ? total_reg - 1'b1 : '0;
                out_data_next.text_height     = glyph_height_reg;
                out_data_next.width_saturated = sat_reg;
                total_next                    = '0;
                sat_next                      = 1'b0;
            end
            else if (s1_add_reg)
            begin
                if (sum >= {1'b0, {TOTAL_BITS{1'b1}}})
                begin
                    total_next = '1;
                    sat_next   = 1'b1;
                end
                else
                begin
                    total_next = sum[TOTAL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_add_reg    <= 1'b0;
            s1_end_reg    <= 1'b0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_add_reg    <= s1_add_next;
            s1_end_reg    <= s1_end_next;
            total_reg     <= total_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_space_reg <= s1_space_next;
        out_data_reg <= out_data_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

endmodule

### sim/tb_text_width_measure.sv
// ----------------------------------------------------------------------------
// tb_text_width_measure
// Self-checking testbench for the text width measurement block.
// ----------------------------------------------------------------------------
// The bench loads the whole glyph width table and then sends text as a stream
// of request items. It covers directed decoder cases, both register extremes,
// phases of random text and a long result hold-off.
// A predictor follows every accepted item, and each result item is compared
// field by field with the oldest predicted measurement.
// ----------------------------------------------------------------------------
module tb_text_width_measure;

    import twm_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam logic [7:0] PREFIX_ACCENT = 8'hC3;
    localparam logic [7:0] PREFIX_PAIR   = 8'hC2;
    localparam logic [7:0] SPACE_BYTE    = 8'h20;
    localparam logic [7:0] BYTE_A        = 8'h41;
    localparam logic [7:0] BYTE_B        = 8'h42;

    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;

    // Cycles to let pass after the last result before the block counts as
    // idle: a byte may still sit in the accumulate stage.
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned FAIL_REPORTS = 10;
    localparam int unsigned PHASE_ITEMS  = 220;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    twm_req_if req_ch ();
    twm_res_if res_ch ();

    text_width_measure dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the width table, the decoder, the
    // running total and the two registers.
    // ------------------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  pred_widths [GLYPH_SLOTS];
    logic [1:0]             dec_mode      = MODE_LEAD;
    logic [1:0]             skip_left     = 2'd0;
    logic [TOTAL_BITS-1:0]  run_width     = '0;
    logic                   run_saturated = 1'b0;
    logic                   gap_cfg       = 1'b1;
    logic [HEIGHT_BITS-1:0] height_cfg    = '0;

    // Measurements predicted but not yet seen on the result channel.
    res_t awaited_measurements [$];

    // Bytes that follow the accent prefix and decode to a glyph.
    logic [7:0] accent_codes [14] = '{8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hB1, 8'h91,
                                      8'h81, 8'h89, 8'h8D, 8'h93, 8'h9A, 8'h9C, 8'hBC};
    // Single-byte Latin-1 capitals that the decoder knows.
    logic [7:0] latin_caps [7] = '{8'hD1, 8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hDC};

    // Run bookkeeping.
    int unsigned failures        = 0;
    int unsigned loads_seen      = 0;
    int unsigned bytes_seen      = 0;
    int unsigned ends_seen       = 0;
    int unsigned results_checked = 0;
    int unsigned saturated_seen  = 0;
    int unsigned settings_used   = 0;
    int unsigned stall_run       = 0;
    int unsigned longest_stall   = 0;
    int unsigned cycle_count     = 0;

    // Idling control: idle_off turns off the random gaps on both sides, and
    // long_hold makes the receiver hold off for that many cycles.
    bit          idle_off  = 1'b0;
    int unsigned long_hold = 0;

    // ------------------------------------------------------------------------
    // Decoder and accumulator of the predictor.
    // ------------------------------------------------------------------------

    // Glyph of a lead byte. Bytes outside the known ranges give no hit.
    function automatic glyph_t lead_glyph(input logic [7:0] b);
        glyph_t g;
        g     = '0;
        g.hit = 1'b1;
        if (b == SPACE_BYTE)
            g.space = 1'b1;
        else if (b >= 8'd33 && b <= 8'd47)
            g.idx = 7'(b - 8'd33 + 8'd64);
        else if (b >= 8'd48 && b <= 8'd57)
            g.idx = 7'(b - 8'd48 + 8'd27);
        else if (b >= 8'd58 && b <= 8'd64)
            g.idx = 7'(b - 8'd58 + 8'd79);
        else if (b >= 8'd65 && b <= 8'd78)
            g.idx = 7'(b - 8'd65);
        else if (b >= 8'd79 && b <= 8'd90)
            g.idx = 7'(b - 8'd79 + 8'd15);
        else if (b >= 8'd91 && b <= 8'd93)
            g.idx = 7'(b - 8'd91 + 8'd86);
        else if (b >= 8'd97 && b <= 8'd110)
            g.idx = 7'(b - 8'd97 + 8'd37);
        else if (b >= 8'd111 && b <= 8'd122)
            g.idx = 7'(b - 8'd111 + 8'd52);
        else if (b >= 8'd123 && b <= 8'd125)
            g.idx = 7'(b - 8'd123 + 8'd89);
        else
        begin
            case (b)
                8'hD1:   g.idx = 7'd14;
                8'hC1:   g.idx = 7'd0;
                8'hC9:   g.idx = 7'd4;
                8'hCD:   g.idx = 7'd8;
                8'hD3:   g.idx = 7'd15;
                8'hDA:   g.idx = 7'd20;
                8'hDC:   g.idx = 7'd20;
                default: g.hit = 1'b0;
            endcase
        end
        return g;
    endfunction

    // Glyph of the byte after an accent prefix.
    function automatic glyph_t accent_glyph(input logic [7:0] b);
        glyph_t g;
        g     = '0;
        g.hit = 1'b1;
        case (b)
            8'hA1:   g.idx = 7'd92;
            8'hA9:   g.idx = 7'd93;
            8'hAD:   g.idx = 7'd94;
            8'hB3:   g.idx = 7'd95;
            8'hBA:   g.idx = 7'd96;
            8'hB1:   g.idx = 7'd51;
            8'h91:   g.idx = 7'd14;
            8'h81:   g.idx = 7'd0;
            8'h89:   g.idx = 7'd4;
            8'h8D:   g.idx = 7'd8;
            8'h93:   g.idx = 7'd15;
            8'h9A:   g.idx = 7'd20;
            8'h9C:   g.idx = 7'd20;
            8'hBC:   g.idx = 7'd58;
            default: g.hit = 1'b0;
        endcase
        return g;
    endfunction

    // Adds to the running total, which clamps at its maximum. The flag is set
    // as soon as the total reaches the maximum, not only when it overshoots.
    function automatic void add_pixels(input longint unsigned amount);
        longint unsigned sum;
        sum = amount + run_width;
        if (sum >= TOTAL_MAX)
        begin
            sum           = TOTAL_MAX;
            run_saturated = 1'b1;
        end
        run_width = sum[TOTAL_BITS-1:0];
    endfunction

    // One nonzero text byte. A byte inside a pending accent pair or a skipped
    // sequence is consumed by that sequence, whatever its value.
    function automatic void decode_byte(input logic [7:0] b);
        glyph_t g;
        g = '0;
        if (dec_mode == MODE_ACCENT)
        begin
            dec_mode = MODE_LEAD;
            g        = accent_glyph(b);
        end
        else if (dec_mode == MODE_SKIP)
        begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 2'd0)
                dec_mode = MODE_LEAD;
        end
        else if (b == PREFIX_ACCENT)
            dec_mode = MODE_ACCENT;
        else if (b == PREFIX_PAIR)
        begin
            dec_mode  = MODE_SKIP;
            skip_left = 2'd1;
        end
        else if (b[7:5] == 3'b111)
        begin
            // Three-byte leads skip two more bytes, four-byte leads three.
            dec_mode  = MODE_SKIP;
            skip_left = b[4] ? 2'd3 : 2'd2;
        end
        else
            g = lead_glyph(b);

        if (g.hit)
        begin
            if (g.space)
                add_pixels(longint'(pred_widths[SPACE_GLYPH]) + gap_cfg);
            else
                add_pixels(longint'(pred_widths[g.idx]) + 1);
        end
    endfunction

    // Works out what one accepted request item does. Only the end of a text
    // produces a measurement; it also clears the decoder and the total.
    function automatic void measure_item(input req_t r);
        res_t m;
        if (r.req_type == REQ_LOAD)
        begin
            pred_widths[r.glyph_slot] = r.width_value[WIDTH_BITS-1:0];
            loads_seen++;
        end
        else if (r.req_type == REQ_BYTE && r.text_byte != 8'h00)
        begin
            decode_byte(r.text_byte);
            bytes_seen++;
        end
        else if (r.req_type != REQ_UNUSED)
        begin
            m.text_width      = (run_width != '0) ? run_width - 1'b1 : '0;
            m.text_height     = height_cfg;
            m.width_saturated = run_saturated;
            awaited_measurements.push_back(m);
            dec_mode      = MODE_LEAD;
            skip_left     = 2'd0;
            run_width     = '0;
            run_saturated = 1'b0;
            ends_seen++;
        end
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= FAIL_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, before any input driven at
    // that edge takes effect, so an item counts exactly when the block takes
    // it.
    // ------------------------------------------------------------------------

    // Request side: feed every accepted item to the predictor and keep track
    // of how long the block has held off its input.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid)
        begin
            if (req_ch.ready)
            begin
                stall_run = 0;
                measure_item(req_ch.data);
            end
            else
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
        end
    end

    // Result side: every accepted result must match the oldest measurement
    // still awaited.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (awaited_measurements.size() == 0)
                note_failure($sformatf("result width %0d height %0d sat %0b with none awaited",
                                       got.text_width, got.text_height, got.width_saturated));
            else
            begin
                want = awaited_measurements.pop_front();
                if (got.text_width !== want.text_width
                    || got.text_height !== want.text_height
                    || got.width_saturated !== want.width_saturated)
                    note_failure($sformatf({"result %0d: expected width %0d height %0d sat %0b, ",
                                            "got width %0d height %0d sat %0b"},
                                           results_checked, want.text_width, want.text_height,
                                           want.width_saturated, got.text_width,
                                           got.text_height, got.width_saturated));
                if (want.width_saturated)
                    saturated_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d measurements still awaited",
                     cycle_count, awaited_measurements.size());
            $display("text_width_measure: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idling. Most gaps are zero or short, a few are long.
    // ------------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (idle_off || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver. A requested long hold-off is counted down here, cycle by
    // cycle, while the sender keeps offering items; otherwise ready drops for
    // random stretches.
    initial
    begin
        int unsigned stall_left;
        stall_left   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold != 0)
            begin
                res_ch.ready <= 1'b0;
                long_hold--;
            end
            else if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
                if (stall_left != 0)
                begin
                    res_ch.ready <= 1'b0;
                    stall_left--;
                end
                else
                    res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. send_item leaves valid high after the handshake so that a
    // following item can go out at the very next edge; whoever stops sending
    // lowers valid through settle.
    // ------------------------------------------------------------------------
    task automatic send_item(input req_t item);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Fields that the request type does not use carry random values, so the
    // block is also shown to ignore them.
    function automatic req_t random_req(input logic [1:0] kind);
        req_t r;
        r.req_type    = kind;
        r.glyph_slot  = 7'($urandom);
        r.width_value = 16'($urandom);
        r.text_byte   = 8'($urandom);
        return r;
    endfunction

    task automatic send_load(input logic [6:0] slot, input logic [15:0] w);
        req_t r;
        r             = random_req(REQ_LOAD);
        r.glyph_slot  = slot;
        r.width_value = w;
        send_item(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        req_t r;
        r           = random_req(REQ_BYTE);
        r.text_byte = b;
        send_item(r);
    endtask

    task automatic send_end();
        send_item(random_req(REQ_END));
    endtask

    task automatic send_unused();
        send_item(random_req(REQ_UNUSED));
    endtask

    // Stops sending and waits until every measurement has come back, then lets
    // the bytes still in the pipeline drain.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_measurements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_SPACE_GAP)
            gap_cfg = value[0];
        else
            height_cfg = value;
    endtask

    // Registers change only with the block idle. The upper bits of the gap
    // write are random, since only bit 0 belongs to the register.
    task automatic set_config(input logic gap, input logic [15:0] height);
        settle();
        write_reg(REG_SPACE_GAP, {15'($urandom), gap});
        write_reg(REG_GLYPH_HEIGHT, height);
        settings_used++;
    endtask

    // One text of random content: mostly well-formed characters and UTF-8
    // sequences, with some noise, loads and unused items mixed in. Returns
    // the number of items that the block acts on.
    task automatic send_random_text(output int unsigned count);
        logic [7:0]  text [$];
        int unsigned units;
        int unsigned u;
        int unsigned roll;
        count = 0;
        units = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        for (u = 0; u < units; u++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                text.push_back(8'($urandom_range(32, 125)));
            else if (roll < 65)
            begin
                // Accented letter; one in four has an accent byte that may
                // not decode.
                text.push_back(PREFIX_ACCENT);
                text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                            : accent_codes[$urandom_range(0, 13)]);
            end
            else if (roll < 70)
                text.push_back(latin_caps[$urandom_range(0, 6)]);
            else if (roll < 75)
            begin
                text.push_back(PREFIX_PAIR);
                text.push_back(8'($urandom_range(1, 255)));
            end
            else if (roll < 80)
            begin
                text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) text.push_back(8'($urandom_range(1, 255)));
            end
            else if (roll < 84)
            begin
                text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                repeat (3) text.push_back(8'($urandom_range(1, 255)));
            end
            else
                // Noise. A zero byte here ends the text early.
                text.push_back(8'($urandom_range(0, 255)));
        end

        foreach (text[i])
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                send_load(7'($urandom), 16'($urandom));
                count++;
            end
            else if (roll < 7)
                send_unused();
            send_byte(text[i]);
            count++;
        end

        if ($urandom_range(0, 4) == 0)
            send_byte(8'h00);
        else
            send_end();
        count++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every slot gets a width before any text is measured, so no byte ever
    // reads an unwritten entry. Slots 5 and 6 get the two extreme widths.
    task automatic test_table_load();
        int unsigned slot;
        for (slot = 0; slot < GLYPH_SLOTS; slot++)
        begin
            if (slot == 5)
                send_load(7'(slot), 16'h0000);
            else if (slot == 6)
                send_load(7'(slot), 16'hFFFF);
            else
                send_load(7'(slot), 16'($urandom));
        end
        settle();
    endtask

    // Decoder cases under the reset register values.
    task automatic test_decode_cases();
        // An empty text measures zero, with no decrement.
        send_end();

        // Letter, space, a good accented letter, an accent prefix that
        // swallows a plain letter, a skipped pair, three- and four-byte
        // sequences, a Latin-1 capital, two bytes the font lacks and a closing brace.
        send_byte(BYTE_A);
        send_byte(SPACE_BYTE);
        send_byte(PREFIX_ACCENT);
        send_byte(8'hA1);
        send_byte(PREFIX_ACCENT);
        send_byte(BYTE_A);
        send_byte(PREFIX_PAIR);
        send_byte(8'hA0);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'h80);
        send_byte(8'hD1);
        send_byte(8'h7E);
        send_byte(8'h01);
        send_byte(8'h7D);
        send_end();

        // A zero text byte ends the text just as an end item does.
        send_byte(8'h7A);
        send_byte(8'h00);

        // An end inside an accent pair drops the prefix, so the next byte
        // decodes as a lead byte again.
        send_byte(PREFIX_ACCENT);
        send_end();
        send_byte(8'h30);
        send_end();

        // The unused request type does nothing, and a load in the middle of
        // a text changes the width for the bytes after it.
        send_byte(BYTE_B);
        send_unused();
        send_load(7'd1, 16'h0003);
        send_byte(BYTE_B);
        send_end();
        settle();
    endtask

    // Both registers at both ends of their ranges; the gap is seen through spaces.
    task automatic test_register_extremes();
        set_config(1'b0, 16'hFFFF);
        send_byte(SPACE_BYTE);
        send_byte(BYTE_A);
        send_byte(SPACE_BYTE);
        send_end();
        set_config(1'b1, 16'h0000);
        send_byte(SPACE_BYTE);
        send_byte(SPACE_BYTE);
        send_end();
        settle();
    endtask

    // Random text in several phases, each under its own register setting.
    // The first two phases use the extremes, and one phase runs without any
    // idling on either side.
    task automatic test_random_text();
        int unsigned phase;
        int unsigned sent;
        int unsigned n;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_config(1'b0, 16'h0000);
            else if (phase == 1)
                set_config(1'b1, 16'hFFFF);
            else
                set_config(1'($urandom), 16'($urandom));
            idle_off = (phase == 3);
            sent     = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_text(n);
                sent += n;
            end
            settle();
            idle_off = 1'b0;
        end
    endtask

    // The receiver holds off for a long stretch while short texts keep
    // coming, so results pile up and the block has to stall its input.
    task automatic test_result_backpressure();
        settle();
        idle_off  = 1'b1;
        long_hold = HOLD_CYCLES;
        repeat (16)
        begin
            send_byte(8'($urandom_range(33, 125)));
            send_byte(8'($urandom_range(33, 125)));
            send_end();
        end
        settle();
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_decode_cases();
        test_register_extremes();
        test_random_text();
        test_result_backpressure();
        settle();

        $display("Covered %0d loads, %0d text bytes and %0d text ends under %0d register settings.",
                 loads_seen, bytes_seen, ends_seen, settings_used);
        $display("Checked %0d results, %0d of them saturated; longest input stall %0d cycles.",
                 results_checked, saturated_seen, longest_stall);
        if (failures == 0)
            $display("text_width_measure: match");
        else
            $display("text_width_measure: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/twm_pkg.sv
rtl/twm_req_if.sv
rtl/twm_res_if.sv
rtl/text_width_measure.sv
sim/tb_text_width_measure.sv
